// ===== hw/rtl/owm_pkg.sv =====
package owm_pkg;

  localparam int REG_W          = 10;
  localparam int NUM_REGS       = 8;
  localparam int CFG_IDX_W      = $clog2(NUM_REGS);
  localparam int TIMER_BITS_DEF = 10;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW    = 3'd0,
    REG_PRESENCE     = 3'd1,
    REG_RESET_REC    = 3'd2,
    REG_WRITE_LOW    = 3'd3,
    REG_WRITE_HOLD   = 3'd4,
    REG_READ_LOW     = 3'd5,
    REG_READ_SAMPLE  = 3'd6,
    REG_READ_REC     = 3'd7
  } reg_idx_t;

  localparam logic [REG_W-1:0] RST_RESET_LOW   = 10'd500;
  localparam logic [REG_W-1:0] RST_PRESENCE    = 10'd70;
  localparam logic [REG_W-1:0] RST_RESET_REC   = 10'd500;
  localparam logic [REG_W-1:0] RST_WRITE_LOW   = 10'd10;
  localparam logic [REG_W-1:0] RST_WRITE_HOLD  = 10'd50;
  localparam logic [REG_W-1:0] RST_READ_LOW    = 10'd5;
  localparam logic [REG_W-1:0] RST_READ_SAMPLE = 10'd5;
  localparam logic [REG_W-1:0] RST_READ_REC    = 10'd50;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RESET = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_REC  = 10'b00_0000_1000,
    PH_W_LOW    = 10'b00_0001_0000,
    PH_W_HOLD   = 10'b00_0010_0000,
    PH_R_LOW    = 10'b00_0100_0000,
    PH_R_WAIT   = 10'b00_1000_0000,
    PH_R_REC    = 10'b01_0000_0000,
    PH_GAP      = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] reset_low_ticks;
    logic [REG_W-1:0] presence_wait_ticks;
    logic [REG_W-1:0] reset_recovery_ticks;
    logic [REG_W-1:0] write_low_ticks;
    logic [REG_W-1:0] write_hold_ticks;
    logic [REG_W-1:0] read_low_ticks;
    logic [REG_W-1:0] read_sample_ticks;
    logic [REG_W-1:0] read_recovery_ticks;
  } owm_cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       presence_level;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } owm_res_t;

endpackage

// ===== hw/rtl/owm_cfg_regs.sv =====
module owm_cfg_regs
  import owm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_data,
  output owm_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks      <= RST_RESET_LOW;
      cfg.presence_wait_ticks  <= RST_PRESENCE;
      cfg.reset_recovery_ticks <= RST_RESET_REC;
      cfg.write_low_ticks      <= RST_WRITE_LOW;
      cfg.write_hold_ticks     <= RST_WRITE_HOLD;
      cfg.read_low_ticks       <= RST_READ_LOW;
      cfg.read_sample_ticks    <= RST_READ_SAMPLE;
      cfg.read_recovery_ticks  <= RST_READ_REC;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_RESET_LOW:   cfg.reset_low_ticks      <= cfg_data;
        REG_PRESENCE:    cfg.presence_wait_ticks  <= cfg_data;
        REG_RESET_REC:   cfg.reset_recovery_ticks <= cfg_data;
        REG_WRITE_LOW:   cfg.write_low_ticks      <= cfg_data;
        REG_WRITE_HOLD:  cfg.write_hold_ticks     <= cfg_data;
        REG_READ_LOW:    cfg.read_low_ticks       <= cfg_data;
        REG_READ_SAMPLE: cfg.read_sample_ticks    <= cfg_data;
        REG_READ_REC:    cfg.read_recovery_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/owm_step.sv =====
module owm_step
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  owm_cfg_t cfg,
  input  action_t  action,
  input  logic [7:0] tx_byte,
  input  logic     line_in,
  output owm_res_t res
);

  localparam int CMP_W = ((TIMER_BITS > REG_W) ? TIMER_BITS : REG_W) + 1;

  phase_t                phase, phase_next, ph_cur;
  logic [TIMER_BITS-1:0] tick_counter, tick_counter_next, cnt_cur;
  logic [2:0]            bit_index, bit_index_next, bit_cur;
  logic [7:0]            shift_byte, shift_byte_next, shift_cur;
  action_t               current_command, current_command_next;
  logic                  presence_seen, presence_seen_next;
  logic [7:0]            rx_hold, rx_hold_next;
  logic [REG_W-1:0]      len;
  logic [CMP_W-1:0]      cnt_inc;
  logic                  last;

  always_comb begin
    ph_cur               = phase;
    cnt_cur              = tick_counter;
    bit_cur              = bit_index;
    shift_cur            = shift_byte;
    current_command_next = current_command;
    if (phase == PH_IDLE && action != ACT_NONE) begin
      current_command_next = action;
      cnt_cur              = '0;
      bit_cur              = '0;
      case (action)
        ACT_RESET: ph_cur = PH_RST_LOW;
        ACT_WRITE: begin
          shift_cur = tx_byte;
          ph_cur    = PH_W_LOW;
        end
        default: begin
          shift_cur = '0;
          ph_cur    = PH_R_LOW;
        end
      endcase
    end

    case (ph_cur)
      PH_RST_LOW:  len = cfg.reset_low_ticks;
      PH_RST_WAIT: len = cfg.presence_wait_ticks;
      PH_RST_REC:  len = cfg.reset_recovery_ticks;
      PH_W_LOW:    len = cfg.write_low_ticks;
      PH_W_HOLD:   len = cfg.write_hold_ticks;
      PH_R_LOW:    len = cfg.read_low_ticks;
      PH_R_WAIT:   len = cfg.read_sample_ticks;
      PH_R_REC:    len = cfg.read_recovery_ticks;
      default:     len = REG_W'(1);
    endcase

    cnt_inc = CMP_W'(cnt_cur) + CMP_W'(1);
    last    = !(cnt_inc < CMP_W'(len));

    phase_next         = ph_cur;
    tick_counter_next  = cnt_cur;
    bit_index_next     = bit_cur;
    shift_byte_next    = shift_cur;
    presence_seen_next = presence_seen;
    rx_hold_next       = rx_hold;
    res.drive_low      = 1'b0;
    res.busy_res       = 1'b0;
    res.done_res       = 1'b0;

    if (ph_cur != PH_IDLE) begin
      res.busy_res = 1'b1;
      if (ph_cur == PH_RST_LOW || ph_cur == PH_W_LOW || ph_cur == PH_R_LOW) begin
        res.drive_low = 1'b1;
      end else if (ph_cur == PH_W_HOLD) begin
        res.drive_low = ~shift_cur[bit_cur];
      end
      if (!last) begin
        tick_counter_next = cnt_inc[TIMER_BITS-1:0];
      end else begin
        tick_counter_next = '0;
        case (ph_cur)
          PH_RST_LOW:  phase_next = PH_RST_WAIT;
          PH_RST_WAIT: begin
            presence_seen_next = line_in;
            phase_next         = PH_RST_REC;
          end
          PH_RST_REC: begin
            res.done_res = 1'b1;
            phase_next   = PH_IDLE;
          end
          PH_W_LOW:    phase_next = PH_W_HOLD;
          PH_W_HOLD:   phase_next = PH_GAP;
          PH_R_LOW:    phase_next = PH_R_WAIT;
          PH_R_WAIT: begin
            shift_byte_next          = shift_cur;
            shift_byte_next[bit_cur] = shift_cur[bit_cur] | line_in;
            phase_next               = PH_R_REC;
          end
          PH_R_REC:    phase_next = PH_GAP;
          PH_GAP: begin
            if (bit_cur == 3'd7) begin
              res.done_res = 1'b1;
              if (current_command_next == ACT_READ) rx_hold_next = shift_cur;
              phase_next = PH_IDLE;
            end else begin
              bit_index_next = bit_cur + 3'd1;
              phase_next     = (current_command_next == ACT_WRITE) ? PH_W_LOW : PH_R_LOW;
            end
          end
          default:     phase_next = PH_IDLE;
        endcase
      end
    end

    res.presence_level = presence_seen_next;
    res.rx_byte        = rx_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_counter    <= '0;
      bit_index       <= '0;
      shift_byte      <= '0;
      current_command <= ACT_NONE;
      presence_seen   <= 1'b1;
      rx_hold         <= '0;
    end else if (adv) begin
      phase           <= phase_next;
      tick_counter    <= tick_counter_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      current_command <= current_command_next;
      presence_seen   <= presence_seen_next;
      rx_hold         <= rx_hold_next;
    end
  end

endmodule

// ===== hw/rtl/one_wire_bus_master_unit.sv =====
// 1-Wire bus master. Each input beat is one timebase tick carrying a command, a byte to send
// and the sampled bus level; each tick yields exactly one output beat with the bus drive,
// busy, done, presence level and last read byte. A tick is taken every cycle whenever the
// output register is empty or being drained, so the sustained rate is one beat per cycle,
// set by the phase sequencer between the tick input and the output register. Each result is
// registered and shown in the cycle after its tick is taken. Reset, write and read commands
// take as many ticks as the programmed durations add up to, plus one release tick after each
// bit slot; commands that arrive while busy are ignored. A zero duration behaves as one tick.
module one_wire_bus_master_unit
  import owm_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // action[1:0], tx_byte[9:2], line_in[10], zero pad
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // drive_low[0], busy_res[1], done_res[2],
                                          // presence_level[3], rx_byte[11:4], zero pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_data
);

  owm_cfg_t cfg;
  owm_res_t res;
  owm_res_t res_q;
  logic     adv;

  assign s_tready = !m_tvalid || m_tready;
  assign adv      = s_tvalid && s_tready;

  owm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  owm_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .cfg     (cfg),
    .action  (action_t'(s_tdata[1:0])),
    .tx_byte (s_tdata[9:2]),
    .line_in (s_tdata[10]),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_tdata = {{(OUT_W - $bits(owm_res_t)){1'b0}}, res_q};

endmodule
